// File: hdl/byte_histogram_alphabet_filter_core_defines.svh
// Assertion macros shared by the byte histogram checker.
// No dependencies; included by bare file name.
`ifndef BYTE_HISTOGRAM_ALPHABET_FILTER_CORE_DEFINES_SVH
`define BYTE_HISTOGRAM_ALPHABET_FILTER_CORE_DEFINES_SVH

// check on every rising clock edge, reset included
`define BHAF_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// check outside of reset
`define BHAF_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: hdl/bhaf_pkg.sv
// Shared types, codes and constants of the byte histogram core.
// No dependencies.
`default_nettype none

package bhaf_pkg;

  localparam int NUM_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int BYTE_W      = 8;
  localparam int OUT_W       = 32;
  localparam int FREQ_FRAC   = 16;
  localparam int FREQ_W      = FREQ_FRAC + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int MASK_W      = 64;
  localparam int NUM_MASKS   = 4;
  localparam int MASK_SEL_W  = 2;
  localparam int MASK_BIT_W  = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'd65;
  localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'd90;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;
  localparam logic [BYTE_W-1:0] LOWER_FIRST = UPPER_FIRST + CASE_OFFSET;
  localparam logic [BYTE_W-1:0] LOWER_LAST  = UPPER_LAST + CASE_OFFSET;

  localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1) << FREQ_FRAC;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_0         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_1         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_2         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_3         = 3'd5;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_COUNT,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] byte_value;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0]  bin_count;
    logic [OUT_W-1:0]  total_bytes;
    logic [FREQ_W-1:0] frequency;
  } rsp_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] bin;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: hdl/bhaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bhaf_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/bhaf_front.sv
// Front end: configuration registers, request intake, case folding and
// alphabet filtering. Depends on bhaf_pkg.
`default_nettype none

module bhaf_front #(
  parameter int NUM_BINS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  bhaf_pkg::req_t                   req,
  input  logic                             cfg_we,
  input  logic [bhaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bhaf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output bhaf_pkg::cmd_t                   cmd
);
  import bhaf_pkg::*;

  logic              text_mode;
  logic              case_sensitive;
  logic [MASK_W-1:0] mask [NUM_MASKS];

  logic              fold;
  logic [BYTE_W-1:0] bin;
  logic              member;
  logic              in_range;
  logic              keep;
  op_t               op;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_mode      <= 1'b1;
      case_sensitive <= 1'b0;
      for (int i = 0; i < NUM_MASKS; i++) begin
        mask[i] <= '1;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_MODE:      text_mode      <= cfg_data[0];
        REG_CASE_SENSITIVE: case_sensitive <= cfg_data[0];
        REG_MASK_0:         mask[0]        <= cfg_data[MASK_W-1:0];
        REG_MASK_1:         mask[1]        <= cfg_data[MASK_W-1:0];
        REG_MASK_2:         mask[2]        <= cfg_data[MASK_W-1:0];
        REG_MASK_3:         mask[3]        <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fold = text_mode && !case_sensitive &&
           (req.byte_value >= LOWER_FIRST) && (req.byte_value <= LOWER_LAST);
    bin      = fold ? (req.byte_value - CASE_OFFSET) : req.byte_value;
    member   = mask[bin[BYTE_W-1 -: MASK_SEL_W]][bin[MASK_BIT_W-1:0]];
    in_range = {1'b0, req.byte_value} < (BYTE_W+1)'(NUM_BINS);
    unique case (req.action)
      ACT_CLEAR: begin
        op   = OP_CLEAR;
        keep = 1'b1;
      end
      ACT_COUNT: begin
        op   = OP_COUNT;
        keep = in_range && (!text_mode || member);
      end
      ACT_READ: begin
        op   = OP_READ;
        keep = 1'b1;
      end
      default: begin
        op   = OP_CLEAR;
        keep = 1'b0;
      end
    endcase
  end

  assign req_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_ready) begin
      cmd_valid <= req_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd.op       <= op;
      cmd.bin      <= (op == OP_COUNT) ? bin : req.byte_value;
      cmd.in_range <= in_range;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bhaf_queue.sv
// Short command queue between the front end and the histogram engine.
// Depends on bhaf_pkg.
`default_nettype none

module bhaf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bhaf_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output bhaf_pkg::cmd_t out_cmd
);
  import bhaf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = fill != CNT_W'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bhaf_div.sv
// Bit-serial Q1.16 ratio unit: one quotient bit per cycle.
// Depends on bhaf_pkg.
`default_nettype none

module bhaf_div #(
  parameter int NUM_W = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [NUM_W-1:0]              den,
  output bhaf_pkg::div_status_t         status,
  input  logic                          res_ready,
  output logic [bhaf_pkg::FREQ_W-1:0]  quo
);
  import bhaf_pkg::*;

  localparam int STEP_W = $clog2(FREQ_FRAC);

  div_state_t        state;
  div_state_t        state_next;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  den_r;
  logic [STEP_W-1:0] step;
  logic [NUM_W:0]    shifted;
  logic              ge;
  logic              last_step;
  logic              trivial;

  assign shifted   = {rem, 1'b0};
  assign ge        = shifted >= {1'b0, den_r};
  assign last_step = step == STEP_W'(FREQ_FRAC - 1);
  assign trivial   = (den == '0) || (num >= den);

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = trivial ? DIV_HOLD : DIV_RUN;
      DIV_RUN:  if (last_step) state_next = DIV_HOLD;
      DIV_HOLD: if (res_ready) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    status.busy = state != DIV_IDLE;
    status.done = state == DIV_HOLD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      rem   <= num;
      den_r <= den;
      step  <= '0;
      if (den == '0) begin
        quo <= '0;
      end else if (num >= den) begin
        quo <= FREQ_ONE;
      end else begin
        quo <= '0;
      end
    end else if (state == DIV_RUN) begin
      rem  <= ge ? NUM_W'(shifted - {1'b0, den_r}) : shifted[NUM_W-1:0];
      quo  <= {quo[FREQ_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bhaf_back.sv
// Histogram engine: bin store, saturating counts, clear, read and ratio.
// Depends on bhaf_pkg, bhaf_ram and bhaf_div.
`default_nettype none

module bhaf_back #(
  parameter int NUM_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bhaf_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bhaf_pkg::rsp_t rsp
);
  import bhaf_pkg::*;

  localparam int AW = $clog2(NUM_BINS);

  logic                   b_valid;
  cmd_t                   b_cmd;
  logic                   b_done;
  logic [AW-1:0]          b_addr;
  logic [NUM_BINS-1:0]    bin_valid;
  logic                   fwd_valid;
  logic [AW-1:0]          fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] old;
  logic [COUNT_WIDTH-1:0] inc;
  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] rd_bin;
  logic [COUNT_WIDTH-1:0] rd_total;
  logic                   re;
  logic                   we;
  logic                   div_start;
  logic                   res_ready;
  div_status_t            div_stat;
  logic [FREQ_W-1:0]      quo;

  assign b_addr    = b_cmd.bin[AW-1:0];
  assign b_done    = b_valid && ((b_cmd.op != OP_READ) || !div_stat.busy);
  assign cmd_ready = !b_valid || b_done;
  assign re        = cmd_valid && cmd_ready;
  assign we        = b_done && (b_cmd.op == OP_COUNT);
  assign div_start = b_done && (b_cmd.op == OP_READ);
  assign res_ready = !rsp_valid || rsp_ready;

  // latest write wins over the registered read of the same bin
  always_comb begin
    if (!b_cmd.in_range) begin
      old = '0;
    end else if (fwd_valid && (fwd_addr == b_addr)) begin
      old = fwd_data;
    end else if (bin_valid[b_addr]) begin
      old = rdata;
    end else begin
      old = '0;
    end
    inc = (old == '1) ? old : old + 1'b1;
  end

  bhaf_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (b_addr),
    .wdata (inc),
    .re    (re),
    .raddr (cmd.bin[AW-1:0]),
    .rdata (rdata)
  );

  bhaf_div #(
    .NUM_W (COUNT_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .num       (old),
    .den       (total),
    .status    (div_stat),
    .res_ready (res_ready),
    .quo       (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      bin_valid <= '0;
      fwd_valid <= 1'b0;
      total     <= '0;
    end else begin
      if (cmd_ready) begin
        b_valid <= cmd_valid;
      end
      if (b_done) begin
        unique case (b_cmd.op)
          OP_CLEAR: begin
            bin_valid <= '0;
            fwd_valid <= 1'b0;
            total     <= '0;
          end
          OP_COUNT: begin
            bin_valid[b_addr] <= 1'b1;
            fwd_valid         <= 1'b1;
            total             <= (total == '1) ? total : total + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      b_cmd <= cmd;
    end
    if (we) begin
      fwd_addr <= b_addr;
      fwd_data <= inc;
    end
    if (div_start) begin
      rd_bin   <= old;
      rd_total <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= div_stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (div_stat.done && res_ready) begin
      rsp.bin_count   <= OUT_W'(rd_bin);
      rsp.total_bytes <= OUT_W'(rd_total);
      rsp.frequency   <= quo;
    end
  end

endmodule

`default_nettype wire

// File: hdl/byte_histogram_alphabet_filter_core.sv
// Byte histogram with case folding and alphabet filter, top level.
// Depends on bhaf_pkg, bhaf_front, bhaf_queue and bhaf_back.
//
// Requests arrive on req (valid/ready): action clear, count byte or read
// bin. Only a read returns a response on rsp (valid/ready): the bin count,
// the total and the bin share of the total in Q1.16.
// Counts and clears are taken one per cycle while the queue has room. A
// read passes the front register, queue, engine stage and ratio unit to
// the output register; the ratio unit skips division when the total is
// zero or the bin holds the whole total, else makes one quotient bit per
// cycle. A read waits in the engine stage until the ratio unit is idle.
// A four-entry queue sits between intake and the bin store, so requests
// keep flowing while the engine waits on the ratio unit, until it fills.
// A stalled response stays in the output register; counts and clears
// behind it continue, a later read waits for the register to free up.
// Reset empties the histogram at once (per-bin valid bits), sets text mode
// with case folding and an all-ones alphabet. Configuration writes take
// effect in the next cycle and apply to bytes accepted afterwards.
`default_nettype none

module byte_histogram_alphabet_filter_core #(
  parameter int NUM_BINS    = bhaf_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = bhaf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  bhaf_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output bhaf_pkg::rsp_t                   rsp,
  input  logic                             cfg_we,
  input  logic [bhaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bhaf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bhaf_pkg::*;

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  bhaf_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bhaf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  bhaf_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: hdl/bhaf_checker.sv
// Port-level checks for the byte histogram core, bound to the top level.
// Depends on bhaf_pkg and byte_histogram_alphabet_filter_core_defines.svh.
`default_nettype none
`include "byte_histogram_alphabet_filter_core_defines.svh"

module bhaf_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input bhaf_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input bhaf_pkg::rsp_t rsp
);
  import bhaf_pkg::*;

  `BHAF_ASSERT(a_reset_empty, clk, rst |=> !rsp_valid, "response valid right after reset")
  `BHAF_ASSERT_RST(a_req_hold, clk, rst, req_valid && !req_ready |=> req_valid && $stable(req), "waiting request changed")
  `BHAF_ASSERT_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "stalled response changed")
  `BHAF_ASSERT_RST(a_freq_range, clk, rst, rsp_valid |-> rsp.frequency <= FREQ_ONE, "frequency above one")
  `BHAF_ASSERT_RST(a_freq_one, clk, rst, rsp_valid && rsp.frequency[FREQ_FRAC] |-> rsp.frequency[FREQ_FRAC-1:0] == '0, "frequency one with fraction bits")

endmodule

bind byte_histogram_alphabet_filter_core bhaf_checker u_checker (.*);

`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for byte_histogram_alphabet_filter_core: directed
// and random requests under random stalls, checked against a histogram model.
// Depends on bhaf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import bhaf_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         PHASE_ITEMS   = 245;

  class hist_scoreboard;
    logic [OUT_W-1:0]  bin_tally [256];
    logic [OUT_W-1:0]  byte_total;
    bit                text_mode;
    bit                case_sens;
    logic [MASK_W-1:0] alpha_mask [NUM_MASKS];
    rsp_t              read_results_q [$];
    int                errors;

    function new();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      byte_total = '0;
      text_mode  = 1'b1;
      case_sens  = 1'b0;
      foreach (alpha_mask[i]) alpha_mask[i] = '1;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TEXT_MODE:      text_mode = val[0];
        REG_CASE_SENSITIVE: case_sens = val[0];
        REG_MASK_0:         alpha_mask[0] = val;
        REG_MASK_1:         alpha_mask[1] = val;
        REG_MASK_2:         alpha_mask[2] = val;
        REG_MASK_3:         alpha_mask[3] = val;
        default: ;
      endcase
    endfunction

    function logic [FREQ_W-1:0] q16_share(logic [OUT_W-1:0] c, logic [OUT_W-1:0] t);
      logic [63:0] wide;
      if (t == '0) return '0;
      if (c >= t) return FREQ_ONE;
      wide = {32'b0, c} << FREQ_FRAC;
      return FREQ_W'(wide / {32'b0, t});
    endfunction

    function void tally_byte(logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] bin;
      bin = b;
      if (text_mode) begin
        if (!case_sens && bin >= LOWER_FIRST && bin <= LOWER_LAST) bin = bin - CASE_OFFSET;
        if (!alpha_mask[bin[7:6]][bin[5:0]]) return;
      end
      if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 1'b1;
      if (byte_total != '1) byte_total = byte_total + 1'b1;
    endfunction

    function void take_request(req_t r);
      rsp_t want;
      case (r.action)
        ACT_CLEAR: begin
          foreach (bin_tally[i]) bin_tally[i] = '0;
          byte_total = '0;
        end
        ACT_COUNT: tally_byte(r.byte_value);
        ACT_READ: begin
          want.bin_count   = bin_tally[r.byte_value];
          want.total_bytes = byte_total;
          want.frequency   = q16_share(bin_tally[r.byte_value], byte_total);
          read_results_q.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (read_results_q.size() == 0) begin
        $error("unexpected response: bin_count %0d total_bytes %0d frequency %0d",
               got.bin_count, got.total_bytes, got.frequency);
        errors++;
        return;
      end
      want = read_results_q.pop_front();
      if (got.bin_count !== want.bin_count) begin
        $error("bin_count: expected %0d, actual %0d", want.bin_count, got.bin_count);
        errors++;
      end
      if (got.total_bytes !== want.total_bytes) begin
        $error("total_bytes: expected %0d, actual %0d", want.total_bytes, got.total_bytes);
        errors++;
      end
      if (got.frequency !== want.frequency) begin
        $error("frequency: expected %0d, actual %0d", want.frequency, got.frequency);
        errors++;
      end
    endfunction

    function int pending();
      return read_results_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hist_scoreboard board = new();
  bit             idle_en = 1'b1;
  int             rsp_stall_left = 0;
  logic [7:0]     hot_bytes [4];

  byte_histogram_alphabet_filter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // response side: check accepted responses, stall in short bursts
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp);
    if (rsp_stall_left > 0) begin
      rsp_ready <= 1'b0;
      rsp_stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rsp_ready <= 1'b0;
      rsp_stall_left = $urandom_range(0, 2);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic send_req(logic [1:0] act, logic [BYTE_W-1:0] val);
    req_t r;
    r.action     = act;
    r.byte_value = val;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    board.take_request(r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // hold off requests until every read has answered and the queue has drained
  task automatic settle();
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return UPPER_FIRST + 8'($urandom_range(0, 25));
    if (sel < 45) return LOWER_FIRST + 8'($urandom_range(0, 25));
    if (sel < 62) return hot_bytes[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 68) send_req(ACT_COUNT, pick_byte());
    else if (roll < 90) send_req(ACT_READ, pick_byte());
    else if (roll < 93) send_req(ACT_CLEAR, 8'($urandom_range(0, 255)));
    else send_req(ACT_UNUSED, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(bit tm, bit cs, logic [MASK_W-1:0] m0, logic [MASK_W-1:0] m1,
                           logic [MASK_W-1:0] m2, logic [MASK_W-1:0] m3);
    settle();
    write_reg(REG_TEXT_MODE, CFG_DATA_W'(tm));
    write_reg(REG_CASE_SENSITIVE, CFG_DATA_W'(cs));
    write_reg(REG_MASK_0, m0);
    write_reg(REG_MASK_1, m1);
    write_reg(REG_MASK_2, m2);
    write_reg(REG_MASK_3, m3);
    cfg_we <= 1'b0;
    foreach (hot_bytes[i]) hot_bytes[i] = 8'($urandom_range(0, 255));
    repeat (PHASE_ITEMS) random_request();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: text mode, folding on, full alphabet
    send_req(ACT_READ, UPPER_FIRST);
    send_req(ACT_COUNT, LOWER_FIRST);
    send_req(ACT_COUNT, LOWER_LAST);
    send_req(ACT_COUNT, UPPER_FIRST);
    send_req(ACT_COUNT, UPPER_LAST);
    send_req(ACT_COUNT, 8'h00);
    send_req(ACT_COUNT, 8'hFF);
    send_req(ACT_COUNT, LOWER_FIRST - 8'd1);
    send_req(ACT_COUNT, LOWER_LAST + 8'd1);
    send_req(ACT_COUNT, UPPER_FIRST - 8'd1);
    send_req(ACT_COUNT, UPPER_LAST + 8'd1);
    send_req(ACT_READ, UPPER_FIRST);
    send_req(ACT_READ, LOWER_FIRST);
    send_req(ACT_READ, UPPER_LAST);
    send_req(ACT_READ, 8'hFF);
    send_req(ACT_UNUSED, 8'hFF);
    send_req(ACT_READ, LOWER_FIRST - 8'd1);
    send_req(ACT_CLEAR, 8'h00);
    send_req(ACT_READ, UPPER_FIRST);
    send_req(ACT_COUNT, 8'h51);
    send_req(ACT_READ, 8'h51);
    send_req(ACT_READ, 8'h52);

    run_phase(1'b1, 1'b0, '1, '1, '1, '1);
    run_phase(1'b0, 1'b0, '0, '0, '0, '0);
    run_phase(1'b1, 1'b1, '0, '0, '0, '0);
    run_phase(1'b1, 1'b0, rand64(), rand64(), rand64(), rand64());
    run_phase(1'b1, 1'b1, rand64(), rand64(), rand64(), rand64());
    run_phase(1'b1, 1'b0, '0, 64'h0000_0000_07FF_FFFE, '0, '0);
    run_phase(1'b0, 1'b1, rand64(), rand64(), rand64(), rand64());
    idle_en = 1'b0;
    run_phase(1'b1, 1'b0, '1, '1, '1, '1);

    settle();
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/bhaf_pkg.sv
hdl/bhaf_ram.sv
hdl/bhaf_front.sv
hdl/bhaf_queue.sv
hdl/bhaf_div.sv
hdl/bhaf_back.sv
hdl/byte_histogram_alphabet_filter_core.sv
hdl/bhaf_checker.sv
sim/tb.sv
